/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files, sampled on clock
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, off while reset is high
`define SEGX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// concurrent assertion that also holds across reset
`define SEGX_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* rtl/segx_pkg.sv */
// ---------------------------------------------------------------------------
// segx_pkg
// Shared constants, step codes and status types of the segment crossing block
// ---------------------------------------------------------------------------
package segx_pkg;

   // default configuration
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 8;

   // width of each crossing coordinate on the result word
   localparam int OUT_W = 24;

   // result tuser bit positions
   localparam int USER_PARALLEL = 0;
   localparam int USER_CROSS    = 1;

   // product sequence of the shared multiplier: even code loads the
   // accumulator, odd code subtracts and stores the difference
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STP_C1_P  = 5'd0;
   localparam logic [STEP_W-1:0] STP_C1_N  = 5'd1;
   localparam logic [STEP_W-1:0] STP_C2_P  = 5'd2;
   localparam logic [STEP_W-1:0] STP_C2_N  = 5'd3;
   localparam logic [STEP_W-1:0] STP_DET_P = 5'd4;
   localparam logic [STEP_W-1:0] STP_DET_N = 5'd5;
   localparam logic [STEP_W-1:0] STP_NX_P  = 5'd6;
   localparam logic [STEP_W-1:0] STP_NX_N  = 5'd7;
   localparam logic [STEP_W-1:0] STP_NY_P  = 5'd8;
   localparam logic [STEP_W-1:0] STP_NY_N  = 5'd9;
   localparam logic [STEP_W-1:0] STP_T0_P  = 5'd10;
   localparam logic [STEP_W-1:0] STP_T0_N  = 5'd11;
   localparam logic [STEP_W-1:0] STP_T1_P  = 5'd12;
   localparam logic [STEP_W-1:0] STP_T1_N  = 5'd13;
   localparam logic [STEP_W-1:0] STP_T2_P  = 5'd14;
   localparam logic [STEP_W-1:0] STP_T2_N  = 5'd15;
   localparam logic [STEP_W-1:0] STP_T3_P  = 5'd16;
   localparam logic [STEP_W-1:0] STP_T3_N  = 5'd17;

   // status of the product sequencer toward the top level
   typedef struct packed {
      logic done;
      logic parallel;
      logic crosses;
   } calc_stat_type;

endpackage

/* rtl/segx_calc.sv */
// ---------------------------------------------------------------------------
// segx_calc
// Shared signed multiplier under a step sequencer: line coefficients,
// determinant, numerators and the four orientation tests
// ---------------------------------------------------------------------------
module segx_calc #(
   parameter int  COORD_BITS = segx_pkg::COORD_BITS_DEF,
   localparam int AB_W       = COORD_BITS + 1,
   localparam int C_W        = 2 * COORD_BITS + 1,
   localparam int DET_W      = 2 * COORD_BITS + 3,
   localparam int NUM_W      = 3 * COORD_BITS + 3,
   localparam int PW         = C_W + AB_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [8*COORD_BITS-1:0]       points,
   output segx_pkg::calc_stat_type       stat,
   output logic signed [DET_W-1:0]       det,
   output logic signed [NUM_W-1:0]       numx,
   output logic signed [NUM_W-1:0]       numy
);

   logic [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [COORD_BITS-1:0] cx_ff, cy_ff, dx_ff, dy_ff;

   logic                          issue_ff;
   logic [segx_pkg::STEP_W-1:0]   step_ff;
   logic                          pvld_ff;
   logic [segx_pkg::STEP_W-1:0]   pidx_ff;
   logic signed [PW-1:0]          prod_ff;
   logic signed [PW-1:0]          acc_ff;
   logic signed [C_W-1:0]         c1_ff, c2_ff;
   logic signed [DET_W-1:0]       det_ff;
   logic signed [NUM_W-1:0]       numx_ff, numy_ff;
   logic [3:0]                    ccw_ff;
   logic                          done_ff;

   logic [COORD_BITS-1:0]  ua, va, ub, vb;
   logic                   use_c1, use_c2;
   logic signed [AB_W-1:0] da, db;
   logic signed [C_W-1:0]  opa;
   logic signed [PW-1:0]   prod_in;
   logic signed [NUM_W-1:0] diff;
   logic                   diff_pos;

   // operand selection per step
   always_comb begin
      ua = '0;
      va = '0;
      ub = '0;
      vb = '0;
      use_c1 = 1'b0;
      use_c2 = 1'b0;
      case (step_ff)
         segx_pkg::STP_C1_P:  begin ua = bx_ff; ub = ay_ff; end
         segx_pkg::STP_C1_N:  begin ua = ax_ff; ub = by_ff; end
         segx_pkg::STP_C2_P:  begin ua = dx_ff; ub = cy_ff; end
         segx_pkg::STP_C2_N:  begin ua = cx_ff; ub = dy_ff; end
         segx_pkg::STP_DET_P: begin ua = ay_ff; va = by_ff; ub = dx_ff; vb = cx_ff; end
         segx_pkg::STP_DET_N: begin ua = bx_ff; va = ax_ff; ub = cy_ff; vb = dy_ff; end
         segx_pkg::STP_NX_P:  begin use_c1 = 1'b1; ub = dx_ff; vb = cx_ff; end
         segx_pkg::STP_NX_N:  begin use_c2 = 1'b1; ub = bx_ff; vb = ax_ff; end
         segx_pkg::STP_NY_P:  begin use_c2 = 1'b1; ub = ay_ff; vb = by_ff; end
         segx_pkg::STP_NY_N:  begin use_c1 = 1'b1; ub = cy_ff; vb = dy_ff; end
         segx_pkg::STP_T0_P:  begin ua = dy_ff; va = ay_ff; ub = cx_ff; vb = ax_ff; end
         segx_pkg::STP_T0_N:  begin ua = cy_ff; va = ay_ff; ub = dx_ff; vb = ax_ff; end
         segx_pkg::STP_T1_P:  begin ua = dy_ff; va = by_ff; ub = cx_ff; vb = bx_ff; end
         segx_pkg::STP_T1_N:  begin ua = cy_ff; va = by_ff; ub = dx_ff; vb = bx_ff; end
         segx_pkg::STP_T2_P:  begin ua = cy_ff; va = ay_ff; ub = bx_ff; vb = ax_ff; end
         segx_pkg::STP_T2_N:  begin ua = by_ff; va = ay_ff; ub = cx_ff; vb = ax_ff; end
         segx_pkg::STP_T3_P:  begin ua = dy_ff; va = ay_ff; ub = bx_ff; vb = ax_ff; end
         segx_pkg::STP_T3_N:  begin ua = by_ff; va = ay_ff; ub = dx_ff; vb = ax_ff; end
         default: begin
         end
      endcase
   end

   // coordinate differences and the shared multiplier
   assign da = $signed({1'b0, ua}) - $signed({1'b0, va});
   assign db = $signed({1'b0, ub}) - $signed({1'b0, vb});
   assign opa = use_c1 ? c1_ff :
                use_c2 ? c2_ff : {{(C_W-AB_W){da[AB_W-1]}}, da};
   assign prod_in = opa * db;

   // difference of the two products of a pair
   assign diff = {acc_ff[PW-1], acc_ff} - {prod_ff[PW-1], prod_ff};
   assign diff_pos = !diff[NUM_W-1] && (diff != '0);

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         step_ff  <= '0;
         pvld_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         pvld_ff <= issue_ff;
         done_ff <= pvld_ff && (pidx_ff == segx_pkg::STP_T3_N);
         if (start) begin
            issue_ff <= 1'b1;
            step_ff  <= segx_pkg::STP_C1_P;
         end else if (issue_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == segx_pkg::STP_T3_N) begin
               issue_ff <= 1'b0;
            end
         end
      end
   end

   // operand capture, product register and accumulation
   always_ff @(posedge clock) begin
      if (start) begin
         ax_ff <= points[0*COORD_BITS +: COORD_BITS];
         ay_ff <= points[1*COORD_BITS +: COORD_BITS];
         bx_ff <= points[2*COORD_BITS +: COORD_BITS];
         by_ff <= points[3*COORD_BITS +: COORD_BITS];
         cx_ff <= points[4*COORD_BITS +: COORD_BITS];
         cy_ff <= points[5*COORD_BITS +: COORD_BITS];
         dx_ff <= points[6*COORD_BITS +: COORD_BITS];
         dy_ff <= points[7*COORD_BITS +: COORD_BITS];
      end
      prod_ff <= prod_in;
      pidx_ff <= step_ff;
      if (pvld_ff) begin
         if (!pidx_ff[0]) begin
            acc_ff <= prod_ff;
         end else begin
            case (pidx_ff)
               segx_pkg::STP_C1_N:  c1_ff     <= diff[C_W-1:0];
               segx_pkg::STP_C2_N:  c2_ff     <= diff[C_W-1:0];
               segx_pkg::STP_DET_N: det_ff    <= diff[DET_W-1:0];
               segx_pkg::STP_NX_N:  numx_ff   <= diff;
               segx_pkg::STP_NY_N:  numy_ff   <= diff;
               segx_pkg::STP_T0_N:  ccw_ff[0] <= diff_pos;
               segx_pkg::STP_T1_N:  ccw_ff[1] <= diff_pos;
               segx_pkg::STP_T2_N:  ccw_ff[2] <= diff_pos;
               segx_pkg::STP_T3_N:  ccw_ff[3] <= diff_pos;
               default: begin
               end
            endcase
         end
      end
   end

   // results toward the top level
   assign stat.done     = done_ff;
   assign stat.parallel = (det_ff == '0);
   assign stat.crosses  = (ccw_ff[0] ^ ccw_ff[1]) & (ccw_ff[2] ^ ccw_ff[3]);
   assign det  = det_ff;
   assign numx = numx_ff;
   assign numy = numy_ff;

endmodule

/* rtl/segx_div.sv */
// ---------------------------------------------------------------------------
// segx_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero and saturated to the signed result width
// ---------------------------------------------------------------------------
module segx_div #(
   parameter int  COORD_BITS = segx_pkg::COORD_BITS_DEF,
   parameter int  FRAC_BITS  = segx_pkg::FRAC_BITS_DEF,
   localparam int OUT_W      = segx_pkg::OUT_W,
   localparam int DET_W      = 2 * COORD_BITS + 3,
   localparam int NUM_W      = 3 * COORD_BITS + 3,
   localparam int SN_W       = NUM_W + FRAC_BITS,
   localparam int HW         = SN_W - OUT_W,
   localparam int CMP_W      = (HW > DET_W) ? HW : DET_W,
   localparam int CNT_W      = $clog2(OUT_W)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DET_W-1:0] den,
   output logic                    done,
   output logic signed [OUT_W-1:0] quo
);

   typedef enum logic [3:0] {
      DV_IDLE  = 4'b0001,
      DV_CHECK = 4'b0010,
      DV_ITER  = 4'b0100,
      DV_FIN   = 4'b1000
   } div_state_type;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_W - 1);
   localparam logic [OUT_W-1:0] POS_LIM  = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] NEG_LIM  = {1'b1, {(OUT_W-1){1'b0}}};

   div_state_type     st_ff;
   logic              done_ff;
   logic [DET_W-1:0]  dmag_ff;
   logic [SN_W-1:0]   nmag_ff;
   logic              neg_ff;
   logic              sat_ff;
   logic [DET_W-1:0]  rem_ff;
   logic [OUT_W-1:0]  lo_ff;
   logic [OUT_W-1:0]  q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [OUT_W-1:0]  quo_ff;

   logic [NUM_W-1:0]  num_abs;
   logic [DET_W-1:0]  den_abs;
   logic [HW-1:0]     hi;
   logic              hi_over;
   logic [DET_W:0]    trial;
   logic              q_bit;
   logic [DET_W-1:0]  rem_nx;
   logic [OUT_W-1:0]  quo_nx;

   // operand magnitudes
   assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign den_abs = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);

   // quotient at or above 2^OUT_W saturates before any iteration
   assign hi      = nmag_ff[SN_W-1:OUT_W];
   assign hi_over = CMP_W'(hi) >= CMP_W'(dmag_ff);

   // one restoring step
   assign trial  = {rem_ff, lo_ff[OUT_W-1]};
   assign q_bit  = trial >= {1'b0, dmag_ff};
   assign rem_nx = q_bit ? DET_W'(trial - {1'b0, dmag_ff}) : trial[DET_W-1:0];

   // sign and saturation of the final quotient
   always_comb begin
      if (!neg_ff) begin
         quo_nx = (sat_ff || (q_ff > POS_LIM)) ? POS_LIM : q_ff;
      end else begin
         quo_nx = (sat_ff || (q_ff > NEG_LIM)) ? NEG_LIM : OUT_W'(-q_ff);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= DV_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            DV_IDLE: begin
               if (start) begin
                  st_ff <= DV_CHECK;
               end
            end
            DV_CHECK: st_ff <= hi_over ? DV_FIN : DV_ITER;
            DV_ITER: begin
               if (cnt_ff == CNT_LAST) begin
                  st_ff <= DV_FIN;
               end
            end
            DV_FIN: begin
               done_ff <= 1'b1;
               st_ff   <= DV_IDLE;
            end
            default: st_ff <= DV_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (st_ff)
         DV_IDLE: begin
            if (start) begin
               dmag_ff <= den_abs;
               nmag_ff <= SN_W'(num_abs) << FRAC_BITS;
               neg_ff  <= num[NUM_W-1] ^ den[DET_W-1];
            end
         end
         DV_CHECK: begin
            sat_ff <= hi_over;
            rem_ff <= DET_W'(hi);
            lo_ff  <= nmag_ff[OUT_W-1:0];
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         DV_ITER: begin
            rem_ff <= rem_nx;
            lo_ff  <= lo_ff << 1;
            q_ff   <= {q_ff[OUT_W-2:0], q_bit};
            cnt_ff <= cnt_ff + 1'b1;
         end
         DV_FIN: quo_ff <= quo_nx;
         default: begin
         end
      endcase
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* rtl/segment_intersection_point.sv */
// ---------------------------------------------------------------------------
// segment_intersection_point
// Crossing point of two lines given by segment endpoints, plus a strict
// segment crossing flag
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one word holds the eight endpoint coordinates of two
//   segments. rsp channel: one word per request with cross_x and cross_y
//   (signed, FRAC_BITS fraction bits, saturated) and two flags in tuser.
//   One shared multiplier walks 18 products (line constants, determinant,
//   numerators, orientation tests), then one radix-2 divider runs the x and
//   then the y division, one quotient bit per cycle over 24 bits.
//   A quotient that saturates early skips its bit iterations, and parallel
//   lines skip the divider altogether (no division). The block takes one
//   request at a time; req_tready is high only while idle and returns as
//   the result word becomes valid, so the next request is not taken before
//   the result is posted.
//   A finished result sits in the output register; the next request is
//   taken while it waits, and a later result waits for that register to
//   free up when the receiver stalls.
//   Parallel lines repeat the last crossing given. Reset empties the
//   output register, returns to idle and sets the held crossing to -1.0.
// ---------------------------------------------------------------------------
module segment_intersection_point #(
   parameter int  COORD_BITS = segx_pkg::COORD_BITS_DEF,
   parameter int  FRAC_BITS  = segx_pkg::FRAC_BITS_DEF,
   localparam int OUT_W      = segx_pkg::OUT_W,
   localparam int REQ_W      = 8 * COORD_BITS,
   localparam int DET_W      = 2 * COORD_BITS + 3,
   localparam int NUM_W      = 3 * COORD_BITS + 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // cross_x, cross_y
   output logic [2*OUT_W-1:0] rsp_tdata,
   // lines_parallel, segments_cross
   output logic [1:0]         rsp_tuser
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CALC  = 5'b00010,
      ST_DIVX  = 5'b00100,
      ST_DIVY  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   localparam logic [OUT_W-1:0] HELD_RESET = {OUT_W{1'b1}} << FRAC_BITS;

   state_type               state_ff, state_in;
   logic                    accept;
   logic                    out_free;

   segx_pkg::calc_stat_type stat;
   logic signed [DET_W-1:0] det;
   logic signed [NUM_W-1:0] numx, numy;

   logic                    div_start;
   logic signed [NUM_W-1:0] div_num;
   logic                    div_done;
   logic signed [OUT_W-1:0] div_quo;

   logic                    par_ff, crs_ff;
   logic [OUT_W-1:0]        qx_ff, qy_ff;
   logic [OUT_W-1:0]        held_x_ff, held_y_ff;
   logic                    rsp_vld_ff;
   logic [OUT_W-1:0]        rsp_x_ff, rsp_y_ff;
   logic                    rsp_par_ff, rsp_crs_ff;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_vld_ff || rsp_tready;

   // products, determinant and orientation tests
   segx_calc #(
      .COORD_BITS (COORD_BITS)
   ) u_calc (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .points (req_tdata),
      .stat   (stat),
      .det    (det),
      .numx   (numx),
      .numy   (numy)
   );

   // divider runs x first, then y
   assign div_start = ((state_ff == ST_CALC) && stat.done && !stat.parallel) ||
                      ((state_ff == ST_DIVX) && div_done);
   assign div_num   = (state_ff == ST_CALC) ? numx : numy;

   segx_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (det),
      .done  (div_done),
      .quo   (div_quo)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (stat.done) begin
               state_in = stat.parallel ? ST_WRITE : ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         held_x_ff  <= HELD_RESET;
         held_y_ff  <= HELD_RESET;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_WRITE) && out_free) begin
            rsp_vld_ff <= 1'b1;
            if (!par_ff) begin
               held_x_ff <= qx_ff;
               held_y_ff <= qy_ff;
            end
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // flags and quotients of the item at work, then the output word
   always_ff @(posedge clock) begin
      if ((state_ff == ST_CALC) && stat.done) begin
         par_ff <= stat.parallel;
         crs_ff <= stat.crosses;
      end
      if ((state_ff == ST_DIVX) && div_done) begin
         qx_ff <= div_quo;
      end
      if ((state_ff == ST_DIVY) && div_done) begin
         qy_ff <= div_quo;
      end
      if ((state_ff == ST_WRITE) && out_free) begin
         rsp_x_ff   <= par_ff ? held_x_ff : qx_ff;
         rsp_y_ff   <= par_ff ? held_y_ff : qy_ff;
         rsp_par_ff <= par_ff;
         rsp_crs_ff <= crs_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser[segx_pkg::USER_PARALLEL] = rsp_par_ff;
   assign rsp_tuser[segx_pkg::USER_CROSS]    = rsp_crs_ff;

endmodule

/* rtl/segx_checker.sv */
// ---------------------------------------------------------------------------
// segx_checker
// Port-level checks of the segment crossing block, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segx_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [2*segx_pkg::OUT_W-1:0] rsp_tdata,
   input logic [1:0]                   rsp_tuser
);

   // a stalled result word holds
   `SEGX_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled result word changed")

   // one request at a time: busy right after a request is taken
   `SEGX_ASSERT(a_busy_after_req, (req_tvalid && req_tready |=> !req_tready), "request taken while busy")

   `SEGX_ASSERT(a_busy_two, (req_tvalid && req_tready |-> ##2 !req_tready), "sequencer left too early")

   // reset leaves the block idle with an empty output register
   `SEGX_ASSERT_NR(a_reset_state, (reset |=> !rsp_tvalid && req_tready), "bad state after reset")

endmodule

bind segment_intersection_point segx_checker u_segx_checker (.*);

/* tb/tb_segment_intersection_point.sv */
// ---------------------------------------------------------------------------
// tb_segment_intersection_point
// Self-checking bench for the segment crossing block: a directed table of
// segment pairs, then random pairs of several shapes (wide, clustered,
// parallel, degenerate, edge of range) under four sender/receiver idling
// phases. Every result word's crossing point (or held crossing) and two
// flags are checked against typed table rows or else a local predictor.
// ---------------------------------------------------------------------------
module tb_segment_intersection_point;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CB       = segx_pkg::COORD_BITS_DEF;
   localparam int     FB       = segx_pkg::FRAC_BITS_DEF;
   localparam int     OUT_W    = segx_pkg::OUT_W;
   localparam int     USER_PARALLEL = segx_pkg::USER_PARALLEL;
   localparam int     USER_CROSS    = segx_pkg::USER_CROSS;
   localparam int     CMAX     = (1 << CB) - 1;
   localparam longint FIX_ONE  = longint'(1) << FB;
   localparam longint OUT_MAX  = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint OUT_MIN  = -(longint'(1) << (OUT_W - 1));
   localparam int     PER_PHASE  = 185;
   localparam int     IDLE_LIMIT = 5000;
   localparam int     TAIL_WAIT  = 100;

   // request word, last field in the top bits
   typedef struct packed {
      logic [CB-1:0] sey;
      logic [CB-1:0] sex;
      logic [CB-1:0] ssy;
      logic [CB-1:0] ssx;
      logic [CB-1:0] fey;
      logic [CB-1:0] fex;
      logic [CB-1:0] fsy;
      logic [CB-1:0] fsx;
   } seg_pair_type;

   typedef struct {
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
      logic             parallel;
      logic             crosses;
   } crossing_type;

   typedef struct {
      seg_pair_type pair;
      bit           typed;
      crossing_type want;
   } row_type;

   typedef enum int {
      SHAPE_WIDE,
      SHAPE_BOX,
      SHAPE_PARALLEL,
      SHAPE_POINT,
      SHAPE_EDGE
   } shape_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // fsx, fsy, fex, fey, ssx, ssy, sex, sey
   logic [8*CB-1:0]      req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // cross_x, cross_y
   logic [2*OUT_W-1:0]   rsp_tdata;
   // lines_parallel, segments_cross
   logic [1:0]           rsp_tuser;

   logic [OUT_W-1:0]     held_x;
   logic [OUT_W-1:0]     held_y;
   crossing_type         crossing_q[$];
   row_type              directed_rows[$];
   int                   idle_pct  = 0;
   int                   stall_pct = 0;
   int                   sent_count = 0;
   int                   word_count = 0;
   int                   parallel_seen = 0;
   int                   cross_seen = 0;
   int                   fault_count = 0;
   int                   idle_cycles = 0;

   segment_intersection_point uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // strict left turn of r seen from p toward q
   function automatic bit left_turn(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
      return (ry - py) * (qx - px) > (qy - py) * (rx - px);
   endfunction

   // scaled quotient, truncated toward zero, saturated to the output width
   function automatic logic [OUT_W-1:0] fixed_div(longint num, longint den);
      longint q;
      q = (num * FIX_ONE) / den;
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < OUT_MIN) q = OUT_MIN;
      return q[OUT_W-1:0];
   endfunction

   // crossing of the two lines by Cramer's rule; updates the held crossing
   function automatic crossing_type next_crossing(seg_pair_type p);
      longint ax, ay, bx, by, cx, cy, dx, dy;
      longint a1, b1, c1, a2, b2, c2, det, nx, ny;
      crossing_type r;
      ax = longint'(p.fsx); ay = longint'(p.fsy);
      bx = longint'(p.fex); by = longint'(p.fey);
      cx = longint'(p.ssx); cy = longint'(p.ssy);
      dx = longint'(p.sex); dy = longint'(p.sey);
      a1 = ay - by; b1 = bx - ax; c1 = bx * ay - ax * by;
      a2 = cy - dy; b2 = dx - cx; c2 = dx * cy - cx * dy;
      det = a1 * b2 - b1 * a2;
      nx  = c1 * b2 - b1 * c2;
      ny  = a1 * c2 - c1 * a2;
      if (det != 0) begin
         held_x = fixed_div(nx, det);
         held_y = fixed_div(ny, det);
      end
      r.x        = held_x;
      r.y        = held_y;
      r.parallel = (det == 0);
      r.crosses  = (left_turn(ax, ay, cx, cy, dx, dy) != left_turn(bx, by, cx, cy, dx, dy))
                && (left_turn(ax, ay, bx, by, cx, cy) != left_turn(ax, ay, bx, by, dx, dy));
      return r;
   endfunction

   function automatic seg_pair_type pair_of(int ax, int ay, int bx, int by,
                                            int cx, int cy, int dx, int dy);
      seg_pair_type p;
      p.fsx = CB'(ax); p.fsy = CB'(ay); p.fex = CB'(bx); p.fey = CB'(by);
      p.ssx = CB'(cx); p.ssy = CB'(cy); p.sex = CB'(dx); p.sey = CB'(dy);
      return p;
   endfunction

   function automatic void add_row(seg_pair_type p, bit typed = 1'b0, int ex = 0, int ey = 0,
                                   bit par = 1'b0, bit crs = 1'b0);
      row_type r;
      r.pair  = p;
      r.typed = typed;
      r.want.x = OUT_W'(ex);
      r.want.y = OUT_W'(ey);
      r.want.parallel = par;
      r.want.crosses  = crs;
      directed_rows.push_back(r);
   endfunction

   // one coordinate near the ends of the range or anywhere
   function automatic int edge_coord();
      case ($urandom_range(4))
         0: return 0;
         1: return CMAX;
         2: return 1;
         3: return CMAX - 1;
         default: return $urandom_range(CMAX);
      endcase
   endfunction

   function automatic seg_pair_type random_pair();
      shape_type    shape;
      int           roll, bxo, byo, ddx, ddy, k, ax, ay, cx, cy;
      seg_pair_type p;
      roll = $urandom_range(99);
      if (roll < 30)      shape = SHAPE_WIDE;
      else if (roll < 60) shape = SHAPE_BOX;
      else if (roll < 75) shape = SHAPE_PARALLEL;
      else if (roll < 85) shape = SHAPE_POINT;
      else                shape = SHAPE_EDGE;
      p = pair_of($urandom_range(CMAX), $urandom_range(CMAX), $urandom_range(CMAX),
                  $urandom_range(CMAX), $urandom_range(CMAX), $urandom_range(CMAX),
                  $urandom_range(CMAX), $urandom_range(CMAX));
      case (shape)
         // clustered points: many real crossings, touches and parallels
         SHAPE_BOX: begin
            bxo = $urandom_range(CMAX - 15);
            byo = $urandom_range(CMAX - 15);
            p = pair_of(bxo + $urandom_range(15), byo + $urandom_range(15),
                        bxo + $urandom_range(15), byo + $urandom_range(15),
                        bxo + $urandom_range(15), byo + $urandom_range(15),
                        bxo + $urandom_range(15), byo + $urandom_range(15));
         end
         // same direction vector, possibly reversed: zero determinant
         SHAPE_PARALLEL: begin
            ddx = $urandom_range(510) - 255;
            ddy = $urandom_range(510) - 255;
            k   = $urandom_range(1) ? 1 : -1;
            ax  = 256 + $urandom_range(CMAX - 511);
            ay  = 256 + $urandom_range(CMAX - 511);
            cx  = 256 + $urandom_range(CMAX - 511);
            cy  = 256 + $urandom_range(CMAX - 511);
            p = pair_of(ax, ay, ax + ddx, ay + ddy, cx, cy, cx + k * ddx, cy + k * ddy);
         end
         // one or both segments collapsed to a point
         SHAPE_POINT: begin
            k = $urandom_range(2);
            if (k != 1) begin
               p.fex = p.fsx;
               p.fey = p.fsy;
            end
            if (k != 0) begin
               p.sex = p.ssx;
               p.sey = p.ssy;
            end
         end
         SHAPE_EDGE: begin
            p = pair_of(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                        edge_coord(), edge_coord(), edge_coord(), edge_coord());
         end
         default: ;
      endcase
      return p;
   endfunction

   // present one word, wait for the handshake, queue what it should give
   task automatic send_pair(input row_type r);
      crossing_type want;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r.pair;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = next_crossing(r.pair);
      if (r.typed) want = r.want;
      crossing_q.push_back(want);
      sent_count++;
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      crossing_type want;
      logic [OUT_W-1:0] got_x, got_y;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_x = rsp_tdata[OUT_W-1:0];
         got_y = rsp_tdata[2*OUT_W-1:OUT_W];
         if (rsp_tuser[USER_PARALLEL]) parallel_seen++;
         if (rsp_tuser[USER_CROSS]) cross_seen++;
         if (crossing_q.size() == 0) begin
            if (fault_count < 10)
               $display("result %0d: word with nothing expected, x %h y %h user %b",
                        word_count, got_x, got_y, rsp_tuser);
            fault_count++;
         end else begin
            want = crossing_q.pop_front();
            if (got_x !== want.x || got_y !== want.y
                || rsp_tuser[USER_PARALLEL] !== want.parallel
                || rsp_tuser[USER_CROSS] !== want.crosses) begin
               if (fault_count < 10)
                  $display("result %0d: want x %h y %h p %b c %b, got x %h y %h p %b c %b",
                           word_count, want.x, want.y, want.parallel, want.crosses,
                           got_x, got_y, rsp_tuser[USER_PARALLEL], rsp_tuser[USER_CROSS]);
               fault_count++;
            end
         end
         word_count++;
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d words still expected", crossing_q.size());
            $display("tb_segment_intersection_point NOT OK");
            $finish;
         end
      end
   end

   initial begin
      row_type r;
      held_x = OUT_W'(-FIX_ONE);
      held_y = OUT_W'(-FIX_ONE);

      // directed pairs; typed rows can be read off by hand
      add_row(pair_of(0, 0, 0, 0, 0, 0, 0, 0), 1, -256, -256, 1, 0);
      add_row(pair_of(0, 0, 4, 4, 0, 4, 4, 0), 1, 512, 512, 0, 1);
      add_row(pair_of(0, 0, 1, 1, 0, 1, 1, 2), 1, 512, 512, 1, 0);
      add_row(pair_of(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1, 512, 512, 1, 0);
      add_row(pair_of(0, 0, CMAX, CMAX, 0, CMAX, CMAX, 0));
      // nearly parallel: crossing far off, saturates low then high
      add_row(pair_of(0, 0, CMAX, 1, 0, 1, CMAX - 1, 2));
      add_row(pair_of(0, 1, CMAX, 2, 0, 0, CMAX - 1, 1));
      // shared endpoint and a T junction
      add_row(pair_of(0, 0, 2, 2, 2, 2, 4, 0));
      add_row(pair_of(0, 0, 4, 0, 2, 0, 2, 4));
      // collinear overlap and coincident segments
      add_row(pair_of(0, 0, 4, 4, 1, 1, 3, 3));
      add_row(pair_of(7, 9, 300, 41, 7, 9, 300, 41));
      // crossing at fractional coordinates, then at a negative y coordinate
      add_row(pair_of(1, 0, 2, 3, 0, 2, 3, 1));
      add_row(pair_of(3, 7, 4, 5, 9, 1, 10, 2));
      // lines meet outside both segments
      add_row(pair_of(0, 0, 1, 1, 10, 0, 9, 1));
      // one segment is a point
      add_row(pair_of(5, 5, 5, 5, 0, 0, 10, 3));
      add_row(pair_of('hAAA, 'h555, 'h555, 'hAAA, 'h555, 'h555, 'hAAA, 'hAAA));
      add_row(pair_of('h555, 'hAAA, 'hAAA, 'h555, 'hAAA, 'hAAA, 'h555, 'h555));
      add_row(pair_of(4, 4, 0, 0, 4, 0, 0, 4));
      add_row(pair_of(CMAX, 0, CMAX, CMAX, 0, CMAX, CMAX, CMAX));
      add_row(pair_of(2048, 0, 2048, CMAX, 0, 2048, CMAX, 2048));
      add_row(pair_of(0, CMAX, CMAX, 0, 0, 0, 1, CMAX));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_pair(directed_rows[i]);

      // random pairs over four idling phases
      r.typed = 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         repeat (PER_PHASE) begin
            r.pair = random_pair();
            send_pair(r);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then a quiet tail to catch stray words
      while (crossing_q.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      $display("sent %0d segment pairs (%0d directed), checked %0d result words",
               sent_count, directed_rows.size(), word_count);
      $display("parallel results %0d, crossing segments %0d, mismatches %0d",
               parallel_seen, cross_seen, fault_count);
      if (fault_count == 0 && crossing_q.size() == 0) begin
         $display("tb_segment_intersection_point OK");
      end else begin
         $display("tb_segment_intersection_point NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/segx_pkg.sv
rtl/segx_calc.sv
rtl/segx_div.sv
rtl/segment_intersection_point.sv
rtl/segx_checker.sv
tb/tb_segment_intersection_point.sv
